// ----- src/ptsr_pkg.sv -----
package ptsr_pkg;

    localparam int WORD_W  = 18;
    localparam int COORD_W = 10;
    localparam int PTR_W   = 5;
    localparam int DATA_W  = 4;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } ptsr_op_t;

    localparam logic [COORD_W-1:0] X_MAX      = 10'd255;
    localparam logic [COORD_W-1:0] Y_MAX      = 10'd239;
    localparam logic [7:0]         Y_ACTIVE   = 8'd48;
    localparam logic [7:0]         Y_OFFSET   = 8'd14;
    localparam logic [8:0]         X_OFFSET   = 9'd8;
    localparam logic [12:0]        RECIP_15   = 13'd4370;
    localparam logic [PTR_W-1:0]   PTR_LIMIT  = 5'd19;
    localparam logic [PTR_W-1:0]   PTR_TOP    = 5'd18;

    localparam logic [DATA_W-1:0]  READ_OFF       = 4'h0;
    localparam logic [DATA_W-1:0]  READ_CLK_LOW   = 4'h4;
    localparam logic [DATA_W-1:0]  READ_BIT_SET   = 4'h0;
    localparam logic [DATA_W-1:0]  READ_BIT_CLEAR = 4'h8;

    typedef struct packed {
        logic       frame_en;
        logic       write_en;
        logic [1:0] write_value;
    } ptsr_cmd_t;

endpackage

// ----- src/ptsr_word.sv -----
module ptsr_word
    import ptsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ptsr_cmd_t          cmd,
    input  logic [COORD_W-1:0] cursor_x,
    input  logic [COORD_W-1:0] cursor_y,
    input  logic               pen_button,
    output logic [WORD_W-1:0]  pending_word
);

    logic [WORD_W-1:0] pending_word_reg;
    logic [WORD_W-1:0] pending_word_next;
    logic              off_surface;
    logic [7:0]        px;
    logic [7:0]        py;
    logic [8:0]        x_sum;
    logic [16:0]       x_prod;
    logic [7:0]        sx;
    logic [7:0]        y_diff;
    logic [11:0]       y_num;
    logic [24:0]       y_prod;
    logic [7:0]        sy;
    logic              w1;

    always_comb
    begin
        off_surface = (cursor_x > X_MAX) || (cursor_y > Y_MAX);
        px = off_surface ? 8'd0 : cursor_x[7:0];
        py = off_surface ? 8'd0 : cursor_y[7:0];
        w1 = (py >= Y_ACTIVE) || pen_button;
        x_sum  = {1'b0, px} + X_OFFSET;
        x_prod = {x_sum, 7'd0, 1'b0} - {4'd0, x_sum, 4'd0};
        sx     = x_prod[15:8];
        y_diff = py - Y_OFFSET;
        y_num  = {y_diff, 4'd0};
        y_prod = {13'd0, y_num} * {12'd0, RECIP_15};
        sy     = (py < Y_OFFSET) ? 8'd0 : y_prod[23:16];
        pending_word_next = cmd.frame_en ? {sx, sy, w1, pen_button} : pending_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_word_reg <= '0;
        end
        else
        begin
            pending_word_reg <= pending_word_next;
        end
    end

    assign pending_word = pending_word_reg;

endmodule

// ----- src/ptsr_port.sv -----
module ptsr_port
    import ptsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ptsr_cmd_t         cmd,
    input  logic [WORD_W-1:0] pending_word,
    output logic [DATA_W-1:0] read_value
);

    logic [WORD_W-1:0] latched_word_reg;
    logic [WORD_W-1:0] latched_word_next;
    logic [1:0]        strobe_reg;
    logic [1:0]        strobe_next;
    logic [PTR_W-1:0]  pointer_reg;
    logic [PTR_W-1:0]  pointer_next;
    logic [WORD_W:0]   test_vec;
    logic [PTR_W-1:0]  bit_index;

    always_comb
    begin
        latched_word_next = latched_word_reg;
        strobe_next       = strobe_reg;
        pointer_next      = pointer_reg;
        if (cmd.write_en)
        begin
            strobe_next = cmd.write_value;
            if (!cmd.write_value[0])
            begin
                latched_word_next = pending_word;
                pointer_next      = '0;
            end
            else if (cmd.write_value[1] && !strobe_reg[1] && (pointer_reg < PTR_LIMIT))
            begin
                pointer_next = pointer_reg + 5'd1;
            end
        end
    end

    // read at bit (18 - pointer); bit 18 lies above the word
    always_comb
    begin
        test_vec  = {1'b0, latched_word_reg};
        bit_index = PTR_TOP - pointer_reg;
        if (!strobe_reg[0])
            read_value = READ_OFF;
        else if (!strobe_reg[1])
            read_value = READ_CLK_LOW;
        else if ((pointer_reg < PTR_LIMIT) && test_vec[bit_index])
            read_value = READ_BIT_SET;
        else
            read_value = READ_BIT_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_word_reg <= '0;
            strobe_reg       <= '0;
            pointer_reg      <= '0;
        end
        else
        begin
            latched_word_reg <= latched_word_next;
            strobe_reg       <= strobe_next;
            pointer_reg      <= pointer_next;
        end
    end

endmodule

// ----- src/pen_tablet_serial_reporter_unit.sv -----
// Pen tablet serial reporter. Frame updates (opcode 0) build an 18-bit report
// word from cursor and button; port writes (opcode 1) latch that word or clock
// the bit pointer; port reads (opcode 2) return one result on read_data (0x0,
// 0x4 or 0x8). Opcode 3 is ignored. Each item passes through an input register
// and takes effect as it advances out of it; a read result is loaded into the
// output register at that same edge, so read_data is valid once the read has
// passed through both registers. One item is accepted per clock while the output
// register can drain, so reads follow each other at full rate under out_ready.
module pen_tablet_serial_reporter_unit
    import ptsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [COORD_W-1:0] cursor_x,
    input  logic [COORD_W-1:0] cursor_y,
    input  logic               pen_button,
    input  logic [1:0]         write_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  read_data
);

    logic               in_valid_reg;
    logic               in_valid_next;
    ptsr_op_t           op_reg;
    logic [COORD_W-1:0] cursor_x_reg;
    logic [COORD_W-1:0] cursor_y_reg;
    logic               pen_button_reg;
    logic [1:0]         write_value_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  read_data_reg;
    logic               out_free;
    logic               advance;
    logic               take;
    ptsr_cmd_t          cmd;
    logic [WORD_W-1:0]  pending_word;
    logic [DATA_W-1:0]  read_value;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        advance  = in_valid_reg && ((op_reg != OP_READ) || out_free);
        in_ready = !in_valid_reg || advance;
        take     = in_valid && in_ready;
        in_valid_next = take || (in_valid_reg && !advance);
        cmd.frame_en    = advance && (op_reg == OP_FRAME);
        cmd.write_en    = advance && (op_reg == OP_WRITE);
        cmd.write_value = write_value_reg;
        if (advance && (op_reg == OP_READ))
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // hold the item until its transfer into the core
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg          <= ptsr_op_t'(opcode);
            cursor_x_reg    <= cursor_x;
            cursor_y_reg    <= cursor_y;
            pen_button_reg  <= pen_button;
            write_value_reg <= write_value;
        end
        if (advance && (op_reg == OP_READ))
        begin
            read_data_reg <= read_value;
        end
    end

    ptsr_word u_word
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cursor_x     (cursor_x_reg),
        .cursor_y     (cursor_y_reg),
        .pen_button   (pen_button_reg),
        .pending_word (pending_word)
    );

    ptsr_port u_port
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pending_word (pending_word),
        .read_value   (read_value)
    );

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule
